// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the nearest-neighbor search unit.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pnn_pkg.sv -----
// Types and constants for the nearest-neighbor search unit.
// No dependencies; used by pnn_dist_unit and the top level.
package pnn_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIST_BITS  = 34;
    localparam int INDEX_BITS = 10;
    localparam int SQ_BITS    = 2 * COORD_BITS;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } pnn_req_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] nearest_index;
        logic [DIST_BITS-1:0]  squared_distance;
        logic                  store_empty;
    } pnn_rsp_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } pnn_point_t;

    // Travels alongside each point through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } pnn_tag_t;

endpackage

// ----- sv/pnn_dist_unit.sv -----
// Pipelined squared-distance unit: abs difference, square and sum stages.
// Depends on pnn_pkg.
module pnn_dist_unit
    import pnn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pnn_tag_t             tag_in,
    input  pnn_point_t           ref_pt,
    input  pnn_point_t           qry_pt,
    output pnn_tag_t             tag_out,
    output logic [DIST_BITS-1:0] sq_dist
);

    pnn_tag_t tag_a_reg, tag_b_reg, tag_c_reg;

    logic [COORD_BITS-1:0] adx_reg, ady_reg, adz_reg;
    logic [SQ_BITS-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_BITS-1:0]  sum_reg;

    logic signed [COORD_BITS:0] dx, dy, dz;
    logic [COORD_BITS-1:0]      adx, ady, adz;

    always_comb
    begin
        dx = {ref_pt.x[COORD_BITS-1], ref_pt.x} - {qry_pt.x[COORD_BITS-1], qry_pt.x};
        dy = {ref_pt.y[COORD_BITS-1], ref_pt.y} - {qry_pt.y[COORD_BITS-1], qry_pt.y};
        dz = {ref_pt.z[COORD_BITS-1], ref_pt.z} - {qry_pt.z[COORD_BITS-1], qry_pt.z};
        // magnitude always fits COORD_BITS unsigned
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        adz = dz[COORD_BITS] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= adx;
        ady_reg <= ady;
        adz_reg <= adz;
        sqx_reg <= adx_reg * adx_reg;
        sqy_reg <= ady_reg * ady_reg;
        sqz_reg <= adz_reg * adz_reg;
        sum_reg <= DIST_BITS'(sqx_reg) + DIST_BITS'(sqy_reg) + DIST_BITS'(sqz_reg);
    end

    assign tag_out = tag_c_reg;
    assign sq_dist = sum_reg;

endmodule

// ----- sv/point_nearest_neighbor_search_unit.sv -----
// Channel | Direction | Payload    | Handshake
// req     | in        | pnn_req_t  | req_valid / req_stall
// rsp     | out       | pnn_rsp_t  | rsp_valid / rsp_stall
//
// Clear and load take effect when the request is taken. A query on an empty store
// answers in the cycle after it is taken; otherwise the stored points stream, one
// per cycle, through the memory read stage, the 3-stage distance unit and the
// compare stage, and the result is registered when the last point is compared.
// Reset clears the count, control, query and result registers; the point memory is not cleared.
// req_stall is high during a scan and its drain and while a result is held valid.
// Top level of the nearest-neighbor search unit; depends on pnn_pkg,
// pnn_dist_unit and assert_macros.svh.
`include "assert_macros.svh"

module point_nearest_neighbor_search_unit
    import pnn_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pnn_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pnn_rsp_t rsp
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [DIST_BITS-1:0] best_dist_reg;
    pnn_point_t           qry_reg;
    logic                 rsp_valid_reg;
    pnn_rsp_t             rsp_reg;
    pnn_tag_t             rd_tag_reg;
    pnn_point_t           rd_data_reg;

    pnn_point_t mem [MAX_POINTS];

    logic                 req_fire;
    logic                 load_we;
    logic                 issue;
    logic                 issue_last;
    pnn_tag_t             issue_tag;
    pnn_tag_t             dist_tag;
    logic [DIST_BITS-1:0] scan_dist;
    logic                 take_new;
    logic [IDX_W-1:0]     res_idx;
    logic [DIST_BITS-1:0] res_dist;
    logic [31:0]          res_idx_ext;
    pnn_point_t           req_pt;

    assign req_stall = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign req_fire  = req_valid && !req_stall;
    assign req_pt    = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
    assign load_we   = req_fire && (req.op == OP_LOAD) && (cnt_reg < CNT_W'(MAX_POINTS));

    assign issue      = (state_reg == ST_SCAN);
    assign issue_last = (CNT_W'(addr_reg) + CNT_W'(1)) == cnt_reg;
    assign issue_tag  = '{vld: issue, last: issue && issue_last};

    // point store with one write and one read port: write on load, read during scan
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= req_pt;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg <= issue_tag;
        end
    end

    pnn_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .ref_pt  (rd_data_reg),
        .qry_pt  (qry_reg),
        .tag_out (dist_tag),
        .sq_dist (scan_dist)
    );

    // strict less-than keeps the earliest index on ties
    assign take_new    = (cmp_idx_reg == '0) || (scan_dist < best_dist_reg);
    assign res_idx     = take_new ? cmp_idx_reg : best_idx_reg;
    assign res_dist    = take_new ? scan_dist : best_dist_reg;
    assign res_idx_ext = 32'(res_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            qry_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (req_fire)
            begin
                unique case (req.op)
                    OP_CLEAR:
                    begin
                        cnt_reg <= '0;
                    end
                    OP_LOAD:
                    begin
                        if (load_we)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                    OP_QUERY:
                    begin
                        if (cnt_reg == '0)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_reg       <= '{nearest_index: '0, squared_distance: '0,
                                               store_empty: 1'b1};
                        end
                        else
                        begin
                            qry_reg     <= req_pt;
                            addr_reg    <= '0;
                            cmp_idx_reg <= '0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end

            if (issue)
            begin
                if (issue_last)
                begin
                    state_reg <= ST_DRAIN;
                end
                else
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
            end

            if (dist_tag.vld)
            begin
                best_idx_reg  <= res_idx;
                best_dist_reg <= res_dist;
                cmp_idx_reg   <= cmp_idx_reg + IDX_W'(1);
                if (dist_tag.last)
                begin
                    state_reg     <= ST_IDLE;
                    rsp_valid_reg <= 1'b1;
                    rsp_reg       <= '{nearest_index: res_idx_ext[INDEX_BITS-1:0],
                                       squared_distance: res_dist, store_empty: 1'b0};
                end
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_scan_in_range, (state_reg == ST_SCAN) |-> (CNT_W'(addr_reg) < cnt_reg), "scan address past stored count")
    `ASSERT_SYNC(a_dist_only_busy, dist_tag.vld |-> (state_reg != ST_IDLE), "distance result while idle")
    `ASSERT_SYNC(a_rsp_index_valid, ($rose(rsp_valid_reg) && !rsp_reg.store_empty) |-> (CNT_W'(best_idx_reg) < cnt_reg), "nearest index beyond stored count")

endmodule
